// File: sv/gif_lzw_decoder_unit_defines.svh
// Assertion macros used by the GIF LZW decoder back end
`ifndef GIF_LZW_DECODER_UNIT_DEFINES_SVH
`define GIF_LZW_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define GLZW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GLZW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/glzw_pkg.sv
// Shared types and constants of the GIF LZW decoder
`default_nettype none
package glzw_pkg;

	typedef struct packed {
		logic       is_fetch;
		logic [7:0] data;
	} item_t;

	localparam logic [2:0] ST_TAKEN   = 3'd0;
	localparam logic [2:0] ST_REFUSED = 3'd1;
	localparam logic [2:0] ST_INDEX   = 3'd2;
	localparam logic [2:0] ST_NEED    = 3'd3;
	localparam logic [2:0] ST_CLEAR   = 3'd4;
	localparam logic [2:0] ST_END     = 3'd5;
	localparam logic [2:0] ST_ERROR   = 3'd6;

	typedef enum logic [1:0] {
		PH_WAIT_CLEAR = 2'd0,
		PH_FIRST      = 2'd1,
		PH_RUN        = 2'd2,
		PH_ERROR      = 2'd3
	} phase_t;

endpackage
`default_nettype wire

// File: sv/glzw_front.sv
// Front end: takes input transfers, classifies them and queues them for the decoder
`default_nettype none
module glzw_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire logic            opcode,
	input  wire logic [7:0]      data_byte,
	output logic                 q_valid,
	output glzw_pkg::item_t      q_item,
	input  wire logic            q_pop
);

	glzw_pkg::item_t slot_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;
	logic            push;

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q].is_fetch <= opcode;
			slot_q[wr_ptr_q].data     <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (q_pop) rd_ptr_q <= !rd_ptr_q;
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: sv/glzw_back.sv
// Back end: bit gathering, LZW table walk, string stack and result register
`default_nettype none
`include "gif_lzw_decoder_unit_defines.svh"
module glzw_back #(
	parameter int MAX_CODE_BITS = 12
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	input  wire glzw_pkg::item_t q_item,
	output logic                 q_pop,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic [3:0]      min_code_size,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic [2:0]           status,
	output logic [7:0]           pixel_index,
	output logic                 last_of_string
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP_OUT,
		S_WALK,
		S_FINISH
	} state_t;

	localparam logic [3:0] MaxBits = 4'(MAX_CODE_BITS);

	function automatic logic [3:0] eff_size(input logic [3:0] s);
		logic [3:0] r;
		r = s;
		if (s < 4'd2) r = 4'd2;
		if (s > 4'd8) r = 4'd8;
		return r;
	endfunction

	state_t            state_q;
	glzw_pkg::phase_t  phase_q;
	logic [3:0]        min_q;
	logic [23:0]       buf_q;
	logic [4:0]        cnt_q;
	logic [3:0]        width_q;
	logic [12:0]       nfc_q;
	logic [11:0]       prev_q;
	logic [12:0]       depth_q;
	logic [7:0]        root_q;
	logic [11:0]       code_q;
	logic              kwk_q;
	logic              out_valid_q;
	logic [2:0]        status_q;
	logic [7:0]        pix_q;
	logic              last_q;

	// code table {prefix, suffix} and string stack
	logic [19:0] tbl_mem [4096];
	logic [19:0] tbl_rdata;
	logic [7:0]  stk_mem [4096];
	logic [7:0]  stk_rdata;

	logic        tbl_re, tbl_we, stk_re, stk_we;
	logic [11:0] tbl_ra, tbl_wa, stk_ra, stk_wa;
	logic [19:0] tbl_wd;
	logic [7:0]  stk_wd;

	logic [3:0]  eff_cur;
	logic [12:0] cc;
	logic        can_emit, idle_go, pop_go, decode_go, walk_start, walk_needs;
	logic [11:0] code_w;
	logic [11:0] walk_c;
	logic [11:0] pref;
	logic        is_kwk;
	logic        cfg_go;

	assign eff_cur    = eff_size(min_q);
	assign cc         = 13'd1 << eff_cur;
	assign can_emit   = !out_valid_q || !out_stall;
	assign cfg_ready  = (state_q == S_IDLE);
	assign cfg_go     = cfg_valid && cfg_ready;
	assign idle_go    = (state_q == S_IDLE) && q_valid && can_emit;
	assign q_pop      = idle_go;
	assign pop_go     = idle_go && q_item.is_fetch && (depth_q != 13'd0);
	assign decode_go  = idle_go && q_item.is_fetch && (depth_q == 13'd0)
		&& (phase_q != glzw_pkg::PH_ERROR) && (cnt_q >= {1'b0, width_q});
	assign code_w     = buf_q[11:0] & ((12'd1 << width_q) - 12'd1);
	assign is_kwk     = ({1'b0, code_w} == nfc_q);
	assign walk_start = decode_go && (phase_q == glzw_pkg::PH_RUN)
		&& ({1'b0, code_w} != cc) && ({1'b0, code_w} != cc + 13'd1)
		&& ({1'b0, code_w} <= nfc_q);
	assign walk_c     = is_kwk ? prev_q : code_w;
	assign walk_needs = ({1'b0, walk_c} >= cc + 13'd2);
	assign pref       = tbl_rdata[19:8];

	always_comb begin
		tbl_re = 1'b0;
		tbl_ra = walk_c;
		if (state_q == S_WALK) begin
			tbl_ra = pref;
			tbl_re = ({1'b0, pref} >= cc + 13'd2);
		end else if (walk_start && walk_needs) begin
			tbl_re = 1'b1;
		end
		tbl_we = (state_q == S_FINISH) && can_emit && !nfc_q[12];
		tbl_wa = nfc_q[11:0];
		tbl_wd = {prev_q, root_q};
		stk_re = pop_go;
		stk_ra = 12'(depth_q - 13'd1);
		stk_we = 1'b0;
		stk_wa = depth_q[11:0];
		stk_wd = tbl_rdata[7:0];
		if (state_q == S_WALK) begin
			stk_we = 1'b1;
		end else if ((state_q == S_FINISH) && can_emit && kwk_q) begin
			// unknown code: its string ends with the first index of the previous one
			stk_we = 1'b1;
			stk_wa = 12'd0;
			stk_wd = root_q;
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
		if (tbl_re) tbl_rdata <= tbl_mem[tbl_ra];
		if (stk_we) stk_mem[stk_wa] <= stk_wd;
		if (stk_re) stk_rdata <= stk_mem[stk_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= glzw_pkg::PH_WAIT_CLEAR;
			min_q       <= 4'd8;
			buf_q       <= '0;
			cnt_q       <= '0;
			width_q     <= 4'd9;
			nfc_q       <= 13'd258;
			prev_q      <= '0;
			depth_q     <= '0;
			root_q      <= '0;
			code_q      <= '0;
			kwk_q       <= 1'b0;
			out_valid_q <= 1'b0;
			status_q    <= '0;
			pix_q       <= '0;
			last_q      <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cfg_go) begin
						min_q <= min_code_size;
						if (phase_q == glzw_pkg::PH_WAIT_CLEAR) begin
							width_q <= eff_size(min_code_size) + 4'd1;
							nfc_q   <= (13'd1 << eff_size(min_code_size)) + 13'd2;
						end
					end
					if (idle_go) begin
						out_valid_q <= 1'b1;
						pix_q       <= 8'd0;
						last_q      <= 1'b0;
						if (!q_item.is_fetch) begin
							if (cnt_q > 5'd16) begin
								status_q <= glzw_pkg::ST_REFUSED;
							end else begin
								buf_q    <= buf_q | (24'(q_item.data) << cnt_q);
								cnt_q    <= cnt_q + 5'd8;
								status_q <= glzw_pkg::ST_TAKEN;
							end
						end else if (depth_q != 13'd0) begin
							out_valid_q <= 1'b0;
							depth_q     <= depth_q - 13'd1;
							state_q     <= S_POP_OUT;
						end else if (phase_q == glzw_pkg::PH_ERROR) begin
							status_q <= glzw_pkg::ST_ERROR;
						end else if (cnt_q < {1'b0, width_q}) begin
							status_q <= glzw_pkg::ST_NEED;
						end else begin
							buf_q <= buf_q >> width_q;
							cnt_q <= cnt_q - {1'b0, width_q};
							if ({1'b0, code_w} == cc) begin
								width_q  <= eff_cur + 4'd1;
								nfc_q    <= cc + 13'd2;
								phase_q  <= glzw_pkg::PH_FIRST;
								status_q <= glzw_pkg::ST_CLEAR;
							end else if (phase_q == glzw_pkg::PH_WAIT_CLEAR) begin
								phase_q  <= glzw_pkg::PH_ERROR;
								status_q <= glzw_pkg::ST_ERROR;
							end else if ({1'b0, code_w} == cc + 13'd1) begin
								buf_q    <= '0;
								cnt_q    <= '0;
								width_q  <= eff_cur + 4'd1;
								nfc_q    <= cc + 13'd2;
								phase_q  <= glzw_pkg::PH_WAIT_CLEAR;
								status_q <= glzw_pkg::ST_END;
							end else if (phase_q == glzw_pkg::PH_FIRST) begin
								if ({1'b0, code_w} >= cc) begin
									phase_q  <= glzw_pkg::PH_ERROR;
									status_q <= glzw_pkg::ST_ERROR;
								end else begin
									prev_q   <= code_w;
									phase_q  <= glzw_pkg::PH_RUN;
									status_q <= glzw_pkg::ST_INDEX;
									pix_q    <= code_w[7:0];
									last_q   <= 1'b1;
								end
							end else if ({1'b0, code_w} > nfc_q) begin
								phase_q  <= glzw_pkg::PH_ERROR;
								status_q <= glzw_pkg::ST_ERROR;
							end else begin
								out_valid_q <= 1'b0;
								code_q      <= code_w;
								kwk_q       <= is_kwk;
								depth_q     <= is_kwk ? 13'd1 : 13'd0;
								if (walk_needs) begin
									state_q <= S_WALK;
								end else begin
									root_q  <= walk_c[7:0];
									state_q <= S_FINISH;
								end
							end
						end
					end
				end
				S_POP_OUT: begin
					if (can_emit) begin
						out_valid_q <= 1'b1;
						status_q    <= glzw_pkg::ST_INDEX;
						pix_q       <= stk_rdata;
						last_q      <= (depth_q == 13'd0);
						state_q     <= S_IDLE;
					end
				end
				S_WALK: begin
					depth_q <= depth_q + 13'd1;
					if ({1'b0, pref} < cc + 13'd2) begin
						root_q  <= pref[7:0];
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (can_emit) begin
						out_valid_q <= 1'b1;
						status_q    <= glzw_pkg::ST_INDEX;
						pix_q       <= root_q;
						last_q      <= (depth_q == 13'd0);
						prev_q      <= code_q;
						if (!nfc_q[12]) begin
							nfc_q <= nfc_q + 13'd1;
							if ((nfc_q + 13'd1 == (13'd1 << width_q)) && (width_q < MaxBits))
								width_q <= width_q + 4'd1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign pixel_index    = pix_q;
	assign last_of_string = last_q;

	`GLZW_ASSERT_NEXT(a_err_sticky, phase_q == glzw_pkg::PH_ERROR, phase_q == glzw_pkg::PH_ERROR, "error phase left")
	`GLZW_ASSERT_NOW(a_width_cap, 1'b1, width_q <= MaxBits, "code width above cap")
	`GLZW_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= 5'd24, "bit count beyond buffer")
	`GLZW_ASSERT_NOW(a_walk_depth, state_q == S_WALK, depth_q < 13'd4096, "stack overflow in walk")

endmodule
`default_nettype wire

// File: sv/gif_lzw_decoder_unit.sv
// Top level of the GIF LZW decoder: front queue plus decode engine
//
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | opcode, data_byte
//  out     | out_valid / out_stall| status, pixel_index, last_of_string
//  cfg     | cfg_valid / cfg_ready| min_code_size
//
// Feeds and short fetch answers come straight from the idle state; a stack pop goes through a stack read.
// A new code walks its prefix chain (one table read per link) before its first index is emitted.
// A two-entry queue lets inputs be taken while a result sits in the output register.
// Reset clears control state; the code table and stack are not cleared.
// Output stall holds the engine in place without losing the pending result.
`default_nettype none
module gif_lzw_decoder_unit #(
	parameter int MAX_CODE_BITS = 12
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       opcode,
	input  wire logic [7:0] data_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [2:0]      status,
	output logic [7:0]      pixel_index,
	output logic            last_of_string,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [3:0] min_code_size
);

	logic            q_valid;
	logic            q_pop;
	glzw_pkg::item_t q_item;

	glzw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.data_byte (data_byte),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	glzw_back #(
		.MAX_CODE_BITS (MAX_CODE_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_item         (q_item),
		.q_pop          (q_pop),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.min_code_size  (min_code_size),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.pixel_index    (pixel_index),
		.last_of_string (last_of_string)
	);

endmodule
`default_nettype wire

// File: bench/gif_lzw_decoder_unit_test.sv
// Self-checking testbench for the GIF LZW decoder: LZW streams in, checked index stream out
`timescale 1ns / 1ps
module gif_lzw_decoder_unit_test;

	localparam int WIDTH_CAP  = 12;
	localparam int TABLE_LEN  = 4096;
	localparam int RAND_ITEMS = 1650;

	typedef struct packed {
		logic [2:0] st;
		logic [7:0] px;
		logic       lst;
	} result_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic       opcode;
	logic [7:0] data_byte;
	logic       out_valid;
	logic       out_stall;
	logic [2:0] status;
	logic [7:0] pixel_index;
	logic       last_of_string;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [3:0] cfg_size;

	gif_lzw_decoder_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.pixel_index(pixel_index),
		.last_of_string(last_of_string),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.min_code_size(cfg_size)
	);

	// decoder copies: 0 looks ahead while building stimulus, 1 follows accepted transfers
	logic [3:0]  dec_size [2];
	logic [23:0] dec_bits [2];
	int          dec_nbits [2];
	int          dec_width [2];
	int          dec_free [2];
	int          dec_prev [2];
	int          dec_depth [2];
	glzw_pkg::phase_t dec_phase [2];
	logic [11:0] dec_prefix [2][TABLE_LEN];
	logic [7:0]  dec_suffix [2][TABLE_LEN];
	logic [7:0]  dec_stack [2][TABLE_LEN];

	glzw_pkg::item_t item_q[$];
	result_t pixel_q[$];
	logic [7:0] byte_q[$];

	// stream builder state (the decoder's view of the table while packing codes)
	int          gen_size;
	int          gen_width;
	int          gen_free;
	glzw_pkg::phase_t gen_phase;
	longint unsigned pack_acc;
	int          pack_bits;

	int      n_made;
	int      n_acc;
	int      n_fail;
	int      seen [8];
	bit      run_go;
	bit      quiet;
	bit      long_hold;
	int      in_gap;
	int      out_gap;
	glzw_pkg::item_t drv_item;
	result_t got;
	result_t want;
	logic [2:0] acc_st;
	logic [7:0] acc_px;
	logic       acc_lst;

	function automatic int clamp_size(input logic [3:0] v);
		if (v < 2) return 2;
		if (v > 8) return 8;
		return int'(v);
	endfunction

	function automatic void table_restart(input int m);
		dec_width[m] = clamp_size(dec_size[m]) + 1;
		dec_free[m] = (1 << clamp_size(dec_size[m])) + 2;
	endfunction

	function automatic void decoder_reset(input int m);
		dec_size[m] = 4'd8;
		dec_bits[m] = '0;
		dec_nbits[m] = 0;
		dec_prev[m] = 0;
		dec_depth[m] = 0;
		dec_phase[m] = glzw_pkg::PH_WAIT_CLEAR;
		table_restart(m);
	endfunction

	function automatic void decoder_config(input int m, input logic [3:0] v);
		dec_size[m] = v;
		if (dec_phase[m] == glzw_pkg::PH_WAIT_CLEAR)
			table_restart(m);
	endfunction

	// push the string of code c, last index first
	function automatic void chain_walk(input int m, input int code);
		int c;
		int cc;
		cc = 1 << clamp_size(dec_size[m]);
		c = code & (TABLE_LEN - 1);
		while (c >= cc + 2 && dec_depth[m] < TABLE_LEN) begin
			dec_stack[m][dec_depth[m]] = dec_suffix[m][c];
			dec_depth[m]++;
			c = int'(dec_prefix[m][c]);
		end
		if (dec_depth[m] < TABLE_LEN) begin
			dec_stack[m][dec_depth[m]] = c[7:0];
			dec_depth[m]++;
		end
	endfunction

	function automatic void decode_step(input int m, input logic op, input logic [7:0] b,
			output logic [2:0] st, output logic [7:0] px, output logic lst);
		int cc;
		int code;
		st = glzw_pkg::ST_TAKEN;
		px = '0;
		lst = 1'b0;
		if (!op) begin
			if (dec_nbits[m] > 16)
				st = glzw_pkg::ST_REFUSED;
			else begin
				dec_bits[m] = dec_bits[m] | ({16'd0, b} << dec_nbits[m]);
				dec_nbits[m] += 8;
			end
			return;
		end
		if (dec_depth[m] > 0) begin
			dec_depth[m]--;
			st = glzw_pkg::ST_INDEX;
			px = dec_stack[m][dec_depth[m]];
			lst = (dec_depth[m] == 0);
			return;
		end
		if (dec_phase[m] == glzw_pkg::PH_ERROR) begin
			st = glzw_pkg::ST_ERROR;
			return;
		end
		if (dec_nbits[m] < dec_width[m]) begin
			st = glzw_pkg::ST_NEED;
			return;
		end
		code = int'(dec_bits[m] & ((24'd1 << dec_width[m]) - 24'd1));
		dec_bits[m] = dec_bits[m] >> dec_width[m];
		dec_nbits[m] -= dec_width[m];
		cc = 1 << clamp_size(dec_size[m]);
		if (code == cc) begin
			table_restart(m);
			dec_phase[m] = glzw_pkg::PH_FIRST;
			st = glzw_pkg::ST_CLEAR;
			return;
		end
		if (dec_phase[m] == glzw_pkg::PH_WAIT_CLEAR) begin
			dec_phase[m] = glzw_pkg::PH_ERROR;
			st = glzw_pkg::ST_ERROR;
			return;
		end
		if (code == cc + 1) begin
			dec_bits[m] = '0;
			dec_nbits[m] = 0;
			table_restart(m);
			dec_phase[m] = glzw_pkg::PH_WAIT_CLEAR;
			st = glzw_pkg::ST_END;
			return;
		end
		if (dec_phase[m] == glzw_pkg::PH_FIRST) begin
			if (code >= cc) begin
				dec_phase[m] = glzw_pkg::PH_ERROR;
				st = glzw_pkg::ST_ERROR;
				return;
			end
			dec_prev[m] = code;
			dec_phase[m] = glzw_pkg::PH_RUN;
			st = glzw_pkg::ST_INDEX;
			px = code[7:0];
			lst = 1'b1;
			return;
		end
		if (code > dec_free[m]) begin
			dec_phase[m] = glzw_pkg::PH_ERROR;
			st = glzw_pkg::ST_ERROR;
			return;
		end
		if (code < dec_free[m]) begin
			dec_depth[m] = 0;
			chain_walk(m, code);
		end else begin
			// code not in table yet: previous string plus its own first index
			dec_depth[m] = 1;
			chain_walk(m, dec_prev[m]);
			dec_stack[m][0] = dec_stack[m][dec_depth[m] - 1];
		end
		if (dec_free[m] < TABLE_LEN) begin
			dec_prefix[m][dec_free[m]] = dec_prev[m][11:0];
			dec_suffix[m][dec_free[m]] = dec_stack[m][dec_depth[m] - 1];
			dec_free[m]++;
			if (dec_free[m] == (1 << dec_width[m]) && dec_width[m] < WIDTH_CAP)
				dec_width[m]++;
		end
		dec_prev[m] = code & (TABLE_LEN - 1);
		dec_depth[m]--;
		st = glzw_pkg::ST_INDEX;
		px = dec_stack[m][dec_depth[m]];
		lst = (dec_depth[m] == 0);
	endfunction

	// pack one code LSB first and track what the decoder will make of it
	function automatic void put_code(input int c);
		int cc;
		cc = 1 << gen_size;
		pack_acc = pack_acc | (longint'(c) << pack_bits);
		pack_bits += gen_width;
		while (pack_bits >= 8) begin
			byte_q.push_back(pack_acc[7:0]);
			pack_acc = pack_acc >> 8;
			pack_bits -= 8;
		end
		if (c == cc) begin
			gen_width = gen_size + 1;
			gen_free = cc + 2;
			gen_phase = glzw_pkg::PH_FIRST;
		end else if (c == cc + 1)
			gen_phase = glzw_pkg::PH_WAIT_CLEAR;
		else if (gen_phase == glzw_pkg::PH_FIRST)
			gen_phase = glzw_pkg::PH_RUN;
		else if (gen_free < TABLE_LEN) begin
			gen_free++;
			if (gen_free == (1 << gen_width) && gen_width < WIDTH_CAP)
				gen_width++;
		end
	endfunction

	function automatic void flush_bits();
		if (pack_bits > 0) begin
			byte_q.push_back(pack_acc[7:0]);
			pack_acc = 0;
			pack_bits = 0;
		end
	endfunction

	function automatic int pick_root();
		return $urandom_range((1 << gen_size) - 1, 0);
	endfunction

	// mostly roots keeps prefix chains short
	function automatic int pick_code(input int root_pct);
		int cc;
		int r;
		int top;
		cc = 1 << gen_size;
		r = $urandom_range(99, 0);
		top = (gen_free < TABLE_LEN) ? gen_free : TABLE_LEN;
		if (r < root_pct || gen_free <= cc + 2)
			return pick_root();
		if (r < root_pct + 4 && gen_free < TABLE_LEN)
			return gen_free;
		return $urandom_range(top - 1, cc + 2);
	endfunction

	task automatic offer(input logic op, input logic [7:0] b, output logic [2:0] st);
		glzw_pkg::item_t it;
		logic [7:0] px;
		logic l;
		decode_step(0, op, b, st, px, l);
		it.is_fetch = op;
		it.data = b;
		item_q.push_back(it);
		n_made++;
	endtask

	// interleave feeds of the packed bytes with fetches until the stream is drained
	task automatic play(input bit greedy);
		logic [2:0] st;
		bit need;
		bit refused;
		need = 0;
		refused = 0;
		forever begin
			if (byte_q.size() > 0 && !refused
					&& (greedy || need || $urandom_range(99, 0) < 55)) begin
				offer(1'b0, byte_q[0], st);
				if (st == glzw_pkg::ST_REFUSED)
					refused = 1;
				else
					void'(byte_q.pop_front());
				need = 0;
			end else begin
				offer(1'b1, 8'($urandom), st);
				refused = 0;
				if (byte_q.size() == 0
						&& (st == glzw_pkg::ST_NEED || st == glzw_pkg::ST_ERROR))
					break;
				need = (st == glzw_pkg::ST_NEED);
			end
		end
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (item_q.size() != 0 || in_valid || pixel_q.size() != 0);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_size(input logic [3:0] v);
		wait_idle();
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_size <= v;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		gen_size = clamp_size(v);
		if (gen_phase == glzw_pkg::PH_WAIT_CLEAR) begin
			gen_width = gen_size + 1;
			gen_free = (1 << gen_size) + 2;
		end
		decoder_config(0, v);
		decoder_config(1, v);
	endtask

	task automatic gen_stream(input int ncodes, input int root_pct, input int clr_pct,
			input bit split);
		int i;
		bit did;
		int ns;
		did = 0;
		put_code(1 << gen_size);
		put_code(pick_root());
		for (i = 0; i < ncodes; i++) begin
			if ($urandom_range(99, 0) < clr_pct) begin
				put_code(1 << gen_size);
				put_code(pick_root());
			end else if (split && !did && pack_bits == 0 && gen_phase == glzw_pkg::PH_RUN
					&& i > ncodes / 2) begin
				// size change mid-stream only lands at the next clear
				play(1'b0);
				ns = $urandom_range((gen_width - 1 < 8) ? gen_width - 1 : 8, 2);
				write_size(4'(ns));
				put_code(1 << gen_size);
				put_code(pick_root());
				did = 1;
			end else
				put_code(pick_code(root_pct));
		end
		put_code((1 << gen_size) + 1);
		flush_bits();
		play(1'b0);
	endtask

	initial begin
		clk = 1'b0;
	end

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			decode_step(1, opcode, data_byte, acc_st, acc_px, acc_lst);
			pixel_q.push_back(result_t'({acc_st, acc_px, acc_lst}));
			n_acc++;
		end
		if (!in_valid || !in_stall) begin
			if (!arst_n || !run_go)
				in_valid <= 1'b0;
			else if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				in_valid <= 1'b0;
			end else if (item_q.size() > 0) begin
				drv_item = item_q.pop_front();
				in_valid <= 1'b1;
				opcode <= drv_item.is_fetch;
				data_byte <= drv_item.data;
				if (!quiet && $urandom_range(99, 0) < 6)
					in_gap <= $urandom_range(13, 1);
			end else
				in_valid <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			got = result_t'({status, pixel_index, last_of_string});
			seen[status]++;
			if (pixel_q.size() == 0) begin
				$error("unexpected result: status %0d index %0d", status, pixel_index);
				n_fail++;
			end else begin
				want = pixel_q.pop_front();
				if (got.st !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, got.st);
					n_fail++;
				end
				if (got.px !== want.px) begin
					$error("pixel_index: expected %0d, got %0d", want.px, got.px);
					n_fail++;
				end
				if (got.lst !== want.lst) begin
					$error("last_of_string: expected %0d, got %0d", want.lst, got.lst);
					n_fail++;
				end
			end
		end
		if (out_gap > 0)
			out_gap <= out_gap - 1;
		else if (!quiet && arst_n && $urandom_range(99, 0) < 6)
			out_gap <= $urandom_range(13, 1);
		out_stall <= long_hold || (out_gap > 0);
	end

	// long receiver hold-off so the input side backs up
	initial begin
		long_hold = 1'b0;
		wait (n_acc >= 200);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (500) @(posedge clk);
		long_hold <= 1'b0;
	end

	initial begin
		#3000000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		logic [2:0] st;
		int kind;
		int i;
		logic [3:0] sizes [4];
		sizes = '{4'd15, 4'd0, 4'd8, 4'd2};
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = 1'b0;
		data_byte = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_size = 4'd8;
		run_go = 0;
		quiet = 0;
		in_gap = 0;
		out_gap = 0;
		n_made = 0;
		n_acc = 0;
		n_fail = 0;
		pack_acc = 0;
		pack_bits = 0;
		for (i = 0; i < 8; i++)
			seen[i] = 0;
		decoder_reset(0);
		decoder_reset(1);
		gen_size = 8;
		gen_width = 9;
		gen_free = 258;
		gen_phase = glzw_pkg::PH_WAIT_CLEAR;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_go = 1;

		// directed: empty fetch, then a short size-2 stream with a repeat-pattern code,
		// width growth to 4 bits, a clear mid-stream and back-to-back feeds that overflow
		write_size(4'd2);
		offer(1'b1, 8'hFF, st);
		put_code(4);
		put_code(3);
		put_code(0);
		put_code(7);
		put_code(6);
		put_code(4);
		put_code(1);
		put_code(5);
		flush_bits();
		play(1'b1);

		i = 0;
		while (n_made < RAND_ITEMS - 60) begin
			write_size(i < 4 ? sizes[i] : 4'($urandom_range(15, 0)));
			gen_stream($urandom_range(60, 15), 75, 3, $urandom_range(99, 0) < 35);
			i++;
		end

		// last part: no idling; end on a broken stream, error is sticky
		wait_idle();
		quiet = 1;
		write_size(4'($urandom_range(8, 2)));
		kind = $urandom_range(2, 0);
		if (kind == 0)
			put_code(pick_root());
		else if (kind == 1) begin
			put_code(1 << gen_size);
			put_code((1 << gen_size) + 2);
		end else begin
			put_code(1 << gen_size);
			put_code(pick_root());
			put_code(gen_free + 1);
		end
		flush_bits();
		play(1'b0);
		for (i = 0; i < 12; i++)
			offer(1'($urandom), 8'($urandom), st);

		wait_idle();
		repeat (20) @(negedge clk);
		if (pixel_q.size() != 0) begin
			$error("%0d results never arrived", pixel_q.size());
			n_fail++;
		end
		$display("Run: %0d transfers in, %0d indices, %0d clears, %0d ends", n_acc,
			seen[glzw_pkg::ST_INDEX], seen[glzw_pkg::ST_CLEAR], seen[glzw_pkg::ST_END]);
		$display("     %0d taken, %0d refused, %0d need-data, %0d error answers",
			seen[glzw_pkg::ST_TAKEN], seen[glzw_pkg::ST_REFUSED],
			seen[glzw_pkg::ST_NEED], seen[glzw_pkg::ST_ERROR]);
		if (n_fail == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
